### rtl/aoc_pkg.sv
// -----------------------------------------------------------------------------
// aoc_pkg
// Shared types and constants for the accelerometer offset calibrator.
// -----------------------------------------------------------------------------
package aoc_pkg;

   localparam int ACCEL_W     = 16;
   localparam int DT_W        = 16;
   localparam int VEL_W       = 22;
   localparam int THRESHOLD_W = 8;
   localparam int MEAN_W      = ACCEL_W + 1;
   localparam int CORR_W      = ACCEL_W + 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd13;

   // stored offsets beyond +/-100 m/s^2 (Q8.8) are treated as zero
   localparam logic signed [ACCEL_W-1:0] OFFSET_LIMIT     = 16'sd25600;
   localparam logic signed [ACCEL_W-1:0] OFFSET_LIMIT_NEG = -16'sd25600;

   // velocity: |corr| * dt / 1000 = ((|corr| * dt) >> 3) / 125
   localparam int PROD_W         = CORR_W + DT_W;
   localparam int DT_SHIFT       = 3;
   localparam int DIV_IN_W       = PROD_W - DT_SHIFT;
   localparam int DIV125_SHIFT   = DIV_IN_W + 7;
   localparam int DIV125_RECIP_W = 31;
   localparam int DIV_PROD_W     = DIV_IN_W + DIV125_RECIP_W;
   localparam int VEL_Q_W        = DIV_PROD_W - DIV125_SHIFT;
   localparam logic [DIV125_RECIP_W-1:0] DIV125_RECIP = 31'd1099511628;

   localparam logic [VEL_W-1:0] VEL_MAX = 22'd4194303;

   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic                      sample_valid;
      logic [DT_W-1:0]           delta_ms;
   } req_type;

   typedef struct packed {
      logic [VEL_W-1:0]          vel_x;
      logic [VEL_W-1:0]          vel_y;
      logic [VEL_W-1:0]          vel_z;
      logic                      out_valid;
      logic                      calib_done_now;
      logic                      store_x;
      logic                      store_y;
      logic                      store_z;
      logic signed [ACCEL_W-1:0] offset_out_x;
      logic signed [ACCEL_W-1:0] offset_out_y;
      logic signed [ACCEL_W-1:0] offset_out_z;
   } rsp_type;

endpackage

### rtl/aoc_stream_if.sv
// -----------------------------------------------------------------------------
// aoc_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// -----------------------------------------------------------------------------
interface aoc_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### rtl/accel_offset_calibrator.sv
// -----------------------------------------------------------------------------
// accel_offset_calibrator: offset calibration and per-axis velocity increment
// Stages 1 to 5 are followed by a result register that holds each result for the sink.
// Throughput: one transaction per cycle through a five-stage pipeline while the sink does not stall.
// Reset (synchronous): sums, count, calibration flag and offsets clear to zero.
// -----------------------------------------------------------------------------
module accel_offset_calibrator #(
   parameter int CALIB_SAMPLES = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   aoc_stream_if.sink                      req_chan,
   aoc_stream_if.source                    rsp_chan,
   input  logic                            csr_we,
   input  logic [aoc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [aoc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW         = aoc_pkg::ACCEL_W;
   localparam int SUM_W      = AW + $clog2(CALIB_SAMPLES);
   localparam int COUNT_W    = $clog2(CALIB_SAMPLES + 1);
   localparam int MEAN_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
   localparam int MPROD_W    = 2 * SUM_W + 1;
   // reciprocal of the sample count, exact floor for every sum magnitude
   localparam logic [SUM_W:0] MEAN_RECIP = (SUM_W + 1)'(
      ((64'd1 << MEAN_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(CALIB_SAMPLES - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic signed [AW-1:0]                   cfg_offset_ff [3];
   logic [aoc_pkg::THRESHOLD_W-1:0]        cfg_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cfg_offset_ff[i] <= '0;
         end
         cfg_thr_ff <= aoc_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            aoc_pkg::CSR_OFFSET_X:  cfg_offset_ff[0] <= csr_wdata;
            aoc_pkg::CSR_OFFSET_Y:  cfg_offset_ff[1] <= csr_wdata;
            aoc_pkg::CSR_OFFSET_Z:  cfg_offset_ff[2] <= csr_wdata;
            aoc_pkg::CSR_THRESHOLD: cfg_thr_ff <= csr_wdata[aoc_pkg::THRESHOLD_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline flow control: a stage advances into the next one whenever the
   // next one is empty or moving on itself, so bubbles close up while the
   // result register waits for the sink.
   // ---------------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic out_free, go1, go2, go3, go4, go5;
   logic free1, free2, free3, free4, free5;
   logic accept;

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign go5      = s5_v_ff && out_free;
   assign free5    = !s5_v_ff || go5;
   assign go4      = s4_v_ff && free5;
   assign free4    = !s4_v_ff || go4;
   assign go3      = s3_v_ff && free4;
   assign free3    = !s3_v_ff || go3;
   assign go2      = s2_v_ff && free3;
   assign free2    = !s2_v_ff || go2;
   assign go1      = s1_v_ff && free2;
   assign free1    = !s1_v_ff || go1;

   assign req_chan.ready = free1;
   assign accept         = req_chan.valid && free1;

   // ---------------------------------------------------------------------------
   // Accept stage: accumulate valid samples until the calibration completes
   // ---------------------------------------------------------------------------
   logic signed [AW-1:0]    req_acc [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic [COUNT_W-1:0]      count_ff;
   logic                    calib_ready_ff;
   logic                    collect;
   logic                    done_in;

   assign req_acc[0] = req_chan.payload.accel_x;
   assign req_acc[1] = req_chan.payload.accel_y;
   assign req_acc[2] = req_chan.payload.accel_z;

   // only valid samples count; the last one of the window completes calibration
   assign collect = accept && !calib_ready_ff && req_chan.payload.sample_valid;
   assign done_in = collect && (count_ff == COUNT_LAST);

   // ---------------------------------------------------------------------------
   // Stage 1: mean magnitude of each sum by reciprocal multiply
   // ---------------------------------------------------------------------------
   logic signed [AW-1:0]            s1_acc_ff [3];
   logic                            s1_valid_ff;
   logic [aoc_pkg::DT_W-1:0]        s1_dt_ff;
   logic                            s1_done_ff;
   logic [SUM_W-1:0]                sum_mag [3];
   logic [MPROD_W-1:0]              mean_prod [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_mag[i]   = sum_ff[i][SUM_W-1] ? SUM_W'(-sum_ff[i]) : SUM_W'(sum_ff[i]);
         mean_prod[i] = MPROD_W'(sum_mag[i]) * MPROD_W'(MEAN_RECIP);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: restore the sign, compare with the stored offset, pick the offset
   // ---------------------------------------------------------------------------
   logic signed [AW-1:0]             s2_acc_ff [3];
   logic                             s2_valid_ff;
   logic [aoc_pkg::DT_W-1:0]         s2_dt_ff;
   logic                             s2_done_ff;
   logic [aoc_pkg::MEAN_W-1:0]       s2_qmag_ff [3];
   logic                             s2_neg_ff [3];
   logic signed [aoc_pkg::MEAN_W:0]  mean_val [3];
   logic signed [AW-1:0]             stored_lim [3];
   logic signed [aoc_pkg::MEAN_W:0]  mean_diff [3];
   logic [aoc_pkg::MEAN_W-1:0]       diff_mag [3];
   logic                             adopt [3];
   logic signed [AW-1:0]             chosen [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mean_val[i] = s2_neg_ff[i] ? -$signed({1'b0, s2_qmag_ff[i]})
                                    :  $signed({1'b0, s2_qmag_ff[i]});
         // out-of-range saved offsets count as zero
         stored_lim[i] = (cfg_offset_ff[i] > aoc_pkg::OFFSET_LIMIT ||
                          cfg_offset_ff[i] < aoc_pkg::OFFSET_LIMIT_NEG)
                         ? '0 : cfg_offset_ff[i];
         mean_diff[i] = mean_val[i] - (aoc_pkg::MEAN_W + 1)'(stored_lim[i]);
         diff_mag[i]  = mean_diff[i][aoc_pkg::MEAN_W]
                        ? aoc_pkg::MEAN_W'(-mean_diff[i])
                        : mean_diff[i][aoc_pkg::MEAN_W-1:0];
         adopt[i]     = diff_mag[i] > aoc_pkg::MEAN_W'(cfg_thr_ff);
         chosen[i]    = adopt[i] ? mean_val[i][AW-1:0] : stored_lim[i];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: subtract the offset in use. The completing item enters this
   // stage on the same edge that loads the new offsets, so it and every later
   // item see them; earlier items have already left the stage.
   // ---------------------------------------------------------------------------
   logic signed [AW-1:0]              offset_ff [3];
   logic signed [AW-1:0]              s3_acc_ff [3];
   logic                              s3_valid_ff;
   logic [aoc_pkg::DT_W-1:0]          s3_dt_ff;
   logic                              s3_done_ff;
   logic                              s3_store_ff [3];
   logic signed [aoc_pkg::CORR_W-1:0] corr [3];
   logic [aoc_pkg::CORR_W-1:0]        corr_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         corr[i]     = aoc_pkg::CORR_W'(s3_acc_ff[i]) - aoc_pkg::CORR_W'(offset_ff[i]);
         corr_mag[i] = corr[i][aoc_pkg::CORR_W-1] ? aoc_pkg::CORR_W'(-corr[i])
                                                  : aoc_pkg::CORR_W'(corr[i]);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: magnitude times elapsed milliseconds
   // ---------------------------------------------------------------------------
   logic [aoc_pkg::CORR_W-1:0]  s4_mag_ff [3];
   logic                        s4_valid_ff;
   logic [aoc_pkg::DT_W-1:0]    s4_dt_ff;
   logic                        s4_done_ff;
   logic                        s4_store_ff [3];
   logic signed [AW-1:0]        s4_offs_ff [3];
   logic [aoc_pkg::PROD_W-1:0]  vel_prod [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel_prod[i] = aoc_pkg::PROD_W'(s4_mag_ff[i]) * aoc_pkg::PROD_W'(s4_dt_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: divide by 1000 (shift by 3, then reciprocal of 125) and saturate
   // ---------------------------------------------------------------------------
   logic [aoc_pkg::PROD_W-1:0]     s5_prod_ff [3];
   logic                           s5_valid_ff;
   logic                           s5_done_ff;
   logic                           s5_store_ff [3];
   logic signed [AW-1:0]           s5_offs_ff [3];
   logic [aoc_pkg::DIV_PROD_W-1:0] div_prod [3];
   logic [aoc_pkg::VEL_Q_W-1:0]    vel_q [3];
   logic [aoc_pkg::VEL_W-1:0]      vel_sat [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_prod[i] = aoc_pkg::DIV_PROD_W'(s5_prod_ff[i][aoc_pkg::PROD_W-1:aoc_pkg::DT_SHIFT])
                     * aoc_pkg::DIV_PROD_W'(aoc_pkg::DIV125_RECIP);
         vel_q[i]    = div_prod[i][aoc_pkg::DIV125_SHIFT +: aoc_pkg::VEL_Q_W];
         vel_sat[i]  = (vel_q[i] > aoc_pkg::VEL_Q_W'(aoc_pkg::VEL_MAX))
                       ? aoc_pkg::VEL_MAX : vel_q[i][aoc_pkg::VEL_W-1:0];
      end
   end

   // ---------------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         s3_v_ff        <= 1'b0;
         s4_v_ff        <= 1'b0;
         s5_v_ff        <= 1'b0;
         out_v_ff       <= 1'b0;
         count_ff       <= '0;
         calib_ready_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]    <= '0;
            offset_ff[i] <= '0;
         end
      end else begin
         // each valid bit: set on entry, clear on exit
         s1_v_ff  <= accept || (s1_v_ff && !go1);
         s2_v_ff  <= go1 || (s2_v_ff && !go2);
         s3_v_ff  <= go2 || (s3_v_ff && !go3);
         s4_v_ff  <= go3 || (s4_v_ff && !go4);
         s5_v_ff  <= go4 || (s5_v_ff && !go5);
         out_v_ff <= go5 || (out_v_ff && !rsp_chan.ready);
         if (collect) begin
            count_ff <= COUNT_W'(count_ff + 1'b1);
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(req_acc[i]);
            end
         end
         if (done_in) begin
            calib_ready_ff <= 1'b1;
         end
         // adopt the chosen offsets as the completing item leaves stage 2
         if (go2 && s2_done_ff) begin
            for (int i = 0; i < 3; i++) begin
               offset_ff[i] <= chosen[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Payload registers: load as the item enters each stage
   // ---------------------------------------------------------------------------
   aoc_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            s1_acc_ff[i] <= req_acc[i];
         end
         s1_valid_ff <= req_chan.payload.sample_valid;
         s1_dt_ff    <= req_chan.payload.delta_ms;
         s1_done_ff  <= done_in;
      end
      if (go1) begin
         for (int i = 0; i < 3; i++) begin
            s2_acc_ff[i]  <= s1_acc_ff[i];
            s2_qmag_ff[i] <= mean_prod[i][MEAN_SHIFT +: aoc_pkg::MEAN_W];
            s2_neg_ff[i]  <= sum_ff[i][SUM_W-1];
         end
         s2_valid_ff <= s1_valid_ff;
         s2_dt_ff    <= s1_dt_ff;
         s2_done_ff  <= s1_done_ff;
      end
      if (go2) begin
         for (int i = 0; i < 3; i++) begin
            s3_acc_ff[i]   <= s2_acc_ff[i];
            s3_store_ff[i] <= s2_done_ff && adopt[i];
         end
         s3_valid_ff <= s2_valid_ff;
         s3_dt_ff    <= s2_dt_ff;
         s3_done_ff  <= s2_done_ff;
      end
      if (go3) begin
         for (int i = 0; i < 3; i++) begin
            s4_mag_ff[i]   <= corr_mag[i];
            s4_store_ff[i] <= s3_store_ff[i];
            s4_offs_ff[i]  <= offset_ff[i];
         end
         s4_valid_ff <= s3_valid_ff;
         s4_dt_ff    <= s3_dt_ff;
         s4_done_ff  <= s3_done_ff;
      end
      if (go4) begin
         for (int i = 0; i < 3; i++) begin
            s5_prod_ff[i]  <= vel_prod[i];
            s5_store_ff[i] <= s4_store_ff[i];
            s5_offs_ff[i]  <= s4_offs_ff[i];
         end
         s5_valid_ff <= s4_valid_ff;
         s5_done_ff  <= s4_done_ff;
      end
      if (go5) begin
         out_ff.vel_x          <= vel_sat[0];
         out_ff.vel_y          <= vel_sat[1];
         out_ff.vel_z          <= vel_sat[2];
         out_ff.out_valid      <= s5_valid_ff;
         out_ff.calib_done_now <= s5_done_ff;
         out_ff.store_x        <= s5_store_ff[0];
         out_ff.store_y        <= s5_store_ff[1];
         out_ff.store_z        <= s5_store_ff[2];
         out_ff.offset_out_x   <= s5_offs_ff[0];
         out_ff.offset_out_y   <= s5_offs_ff[1];
         out_ff.offset_out_z   <= s5_offs_ff[2];
      end
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.payload = out_ff;

endmodule

### rtl/aoc_checker.sv
// -----------------------------------------------------------------------------
// aoc_checker
// Port-level checks on the calibrator's result stream.
// -----------------------------------------------------------------------------
module aoc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input aoc_pkg::rsp_type rsp_payload
);

   logic done_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_payload.calib_done_now) begin
         done_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.calib_done_now |-> !done_seen_ff)
      else $error("calibration completed twice");

   a_store_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.store_x || rsp_payload.store_y || rsp_payload.store_z)
      |-> rsp_payload.calib_done_now)
      else $error("store flag outside the completing transaction");

   a_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_seen_ff && !rsp_payload.calib_done_now
      |-> rsp_payload.offset_out_x == '0 && rsp_payload.offset_out_y == '0 &&
          rsp_payload.offset_out_z == '0)
      else $error("offset in use before calibration");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind accel_offset_calibrator aoc_checker u_aoc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
